// File: design/idc_pkg.sv
// Shared types and constants for the isotope distribution convolution block.
// Used by idc_divider and isotope_distribution_convolution; depends on nothing.
package idc_pkg;

  localparam int MAX_PEAKS  = 16;
  localparam int IDX_W      = $clog2(MAX_PEAKS);
  localparam int CNT_W      = $clog2(MAX_PEAKS + 1);
  localparam int SLOT_COUNT = 2 * MAX_PEAKS - 1;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int MASS_W     = 40;
  localparam int PROB_W     = 32;
  localparam int DIV_NW     = 80;
  localparam int DIV_DW     = 40;
  localparam int DIV_CW     = $clog2(DIV_NW);

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_PRUNED   = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic                     action;
    logic signed [MASS_W-1:0] peak_mass;
    logic [PROB_W-1:0]        peak_prob;
    logic                     last_peak;
  } in_item_t;

  typedef struct packed {
    logic signed [MASS_W-1:0] out_mass;
    logic [PROB_W-1:0]        out_prob;
    logic                     out_last;
    logic [1:0]               out_status;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/isotope_distribution_convolution.sv
// Top level of the isotope distribution convolution block: peak stores, sequencer,
// shared multiplier and result register. Depends on idc_pkg and idc_divider.
//
// Peaks load at one item per cycle while the block is idle. The item that ends the second
// list starts a run that holds in_ready low until the last result is loaded into the
// result register. Each pair of peaks passes through the states RD, PP, WT, ML, MH and
// MACC, using the one shared multiplier, and each slot then takes a pass through the
// bit-serial divider for its mass. Each delivered result takes another divider pass.
// A run also waits while the result register holds a result not yet taken on out_ready.
module isotope_distribution_convolution (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  idc_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output idc_pkg::out_item_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import idc_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE = 15'h0001,
    ST_CHK  = 15'h0002,
    ST_SLOT = 15'h0004,
    ST_RD   = 15'h0008,
    ST_PP   = 15'h0010,
    ST_WT   = 15'h0020,
    ST_ML   = 15'h0040,
    ST_MH   = 15'h0080,
    ST_MACC = 15'h0100,
    ST_DIVS = 15'h0200,
    ST_DIVW = 15'h0400,
    ST_FIN  = 15'h0800,
    ST_ERD  = 15'h1000,
    ST_EDIV = 15'h2000,
    ST_EWT  = 15'h4000
  } state_t;

  localparam logic [31:0] CUTOFF_RESET = 32'd2147;
  localparam logic signed [MASS_W-1:0] MASS_MAX = {1'b0, {(MASS_W-1){1'b1}}};
  localparam logic signed [MASS_W-1:0] MASS_MIN = {1'b1, {(MASS_W-1){1'b0}}};

  state_t st_r;
  logic [31:0] cutoff_r;
  logic [CNT_W-1:0] first_cnt_r, second_cnt_r, n0_r, n1_r;
  logic ovf_r;
  logic spec_r;
  status_t spec_stat_r;

  logic [MASS_W-1:0] fm_mem [MAX_PEAKS];
  logic [PROB_W-1:0] fp_mem [MAX_PEAKS];
  logic [MASS_W-1:0] sm_mem [MAX_PEAKS];
  logic [PROB_W-1:0] sp_mem [MAX_PEAKS];
  logic [MASS_W-1:0] mass_mem [SLOT_COUNT];
  logic [31:0]       wt_mem [SLOT_COUNT];
  logic [MASS_W-1:0] fm_rd_r, sm_rd_r, smass_rd_r;
  logic [PROB_W-1:0] fp_rd_r, sp_rd_r;
  logic [31:0]       sw_rd_r;

  logic [SLOT_W-1:0] k_r, ek_r, lo_r, hi_r;
  logic [IDX_W-1:0]  i_r, end_r, j_idx;
  logic [CNT_W:0]    last_k;
  logic [CNT_W-1:0]  start_nxt, end_nxt;

  logic [31:0] mul_a;
  logic [32:0] mul_b;
  logic [63:0] mul_r;
  logic [56:0] part_r;
  logic signed [MASS_W:0] m_r;
  logic [MASS_W:0] mag_r;
  logic neg_r;
  logic [32:0] w_r;
  logic [36:0] wsum_r;
  logic signed [45:0] msum_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [DIV_NW-1:0] acc_r;
  logic [DIV_NW-1:0] prod;
  logic [63:0] w_round;

  logic found_r;
  logic [36:0] tot_all_r, tot_hi_r, tot_nxt;
  logic [31:0] sw_nxt;
  logic mneg_r;
  logic [DIV_NW-1:0] acc_mag;
  logic [45:0] msum_mag;

  logic div_start;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den;
  div_stat_t div_stat;
  logic [MASS_W:0] qc;
  logic signed [MASS_W-1:0] mass_nxt;

  logic out_valid_r;
  out_item_t out_r;
  logic in_fire, cfg_wr;

  idc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? cutoff_r : 32'd0;

  always_comb begin
    j_idx     = IDX_W'(k_r - SLOT_W'(i_r));
    last_k    = (CNT_W+1)'(n0_r) + (CNT_W+1)'(n1_r) - (CNT_W+1)'(2);
    start_nxt = (CNT_W'(k_r) < n1_r - 1'b1) ? '0 : CNT_W'(CNT_W'(k_r) - n1_r + 1'b1);
    end_nxt   = (CNT_W'(k_r) < n0_r - 1'b1) ? CNT_W'(k_r) : CNT_W'(n0_r - 1'b1);
    unique case (st_r)
      ST_ML:   begin mul_a = {8'd0, mag_r[23:0]};          mul_b = w_r; end
      ST_MH:   begin mul_a = {15'd0, mag_r[MASS_W:24]};     mul_b = w_r; end
      default: begin mul_a = fp_rd_r;                        mul_b = {1'b0, sp_rd_r}; end
    endcase
    w_round  = mul_r + 64'h4000_0000;
    prod     = {mul_r[55:0], 24'd0} + {23'd0, part_r};
    acc_mag  = acc_r[DIV_NW-1] ? DIV_NW'(-acc_r) : DIV_NW'(acc_r);
    msum_mag = msum_r[45] ? 46'(-msum_r) : 46'(msum_r);
    sw_nxt   = (wsum_r > 37'hFFFF_FFFF) ? 32'hFFFF_FFFF : wsum_r[31:0];
    tot_nxt  = found_r ? tot_all_r + 37'(sw_nxt) : 37'(sw_nxt);
    div_start = (st_r == ST_DIVS) || (st_r == ST_EDIV);
    if (st_r == ST_EDIV) begin
      div_num = DIV_NW'({sw_rd_r, 31'd0}) + DIV_NW'(tot_hi_r[36:1]);
      div_den = DIV_DW'(tot_hi_r);
    end else if (wsum_r == '0) begin
      div_num = DIV_NW'(msum_mag) + DIV_NW'(cnt_r[CNT_W-1:1]);
      div_den = DIV_DW'(cnt_r);
    end else begin
      div_num = acc_mag + DIV_NW'(wsum_r[36:1]);
      div_den = DIV_DW'(wsum_r);
    end
    qc = (div_quot > (DIV_NW'(1) << MASS_W)) ? ((MASS_W+1)'(1) << MASS_W)
                                             : div_quot[MASS_W:0];
    if (mneg_r) begin
      mass_nxt = (qc >= ((MASS_W+1)'(1) << (MASS_W-1))) ? MASS_MIN : MASS_W'(-qc);
    end else begin
      mass_nxt = (qc > (MASS_W+1)'(MASS_MAX)) ? MASS_MAX : qc[MASS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    fm_rd_r    <= fm_mem[i_r];
    fp_rd_r    <= fp_mem[i_r];
    sm_rd_r    <= sm_mem[j_idx];
    sp_rd_r    <= sp_mem[j_idx];
    smass_rd_r <= mass_mem[ek_r];
    sw_rd_r    <= wt_mem[ek_r];
    if (in_fire && !in_data.action && first_cnt_r < CNT_W'(MAX_PEAKS)) begin
      fm_mem[first_cnt_r[IDX_W-1:0]] <= in_data.peak_mass;
      fp_mem[first_cnt_r[IDX_W-1:0]] <= in_data.peak_prob;
    end
    if (in_fire && in_data.action && second_cnt_r < CNT_W'(MAX_PEAKS)) begin
      sm_mem[second_cnt_r[IDX_W-1:0]] <= in_data.peak_mass;
      sp_mem[second_cnt_r[IDX_W-1:0]] <= in_data.peak_prob;
    end
    if (st_r == ST_DIVW && div_stat.done) begin
      mass_mem[k_r] <= mass_nxt;
      wt_mem[k_r]   <= sw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      cutoff_r     <= CUTOFF_RESET;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      spec_r       <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cutoff_r <= pwdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (!in_data.action) begin
              if (first_cnt_r < CNT_W'(MAX_PEAKS)) first_cnt_r <= first_cnt_r + 1'b1;
              else ovf_r <= 1'b1;
            end else if (!in_data.last_peak) begin
              if (second_cnt_r < CNT_W'(MAX_PEAKS)) second_cnt_r <= second_cnt_r + 1'b1;
              else ovf_r <= 1'b1;
            end else begin
              n0_r <= first_cnt_r;
              n1_r <= (second_cnt_r < CNT_W'(MAX_PEAKS)) ? second_cnt_r + 1'b1
                                                         : second_cnt_r;
              spec_r       <= ovf_r || (second_cnt_r == CNT_W'(MAX_PEAKS))
                              || (first_cnt_r == '0);
              spec_stat_r  <= (ovf_r || (second_cnt_r == CNT_W'(MAX_PEAKS)))
                              ? STAT_OVERFLOW : STAT_PRUNED;
              first_cnt_r  <= '0;
              second_cnt_r <= '0;
              ovf_r        <= 1'b0;
              found_r      <= 1'b0;
              k_r          <= '0;
              st_r         <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          if (spec_r) begin
            if (!out_valid_r) begin
              out_r       <= '{out_mass: '0, out_prob: '0, out_last: 1'b1,
                               out_status: spec_stat_r};
              out_valid_r <= 1'b1;
              spec_r      <= 1'b0;
              st_r        <= ST_IDLE;
            end
          end else begin
            st_r <= ST_SLOT;
          end
        end
        ST_SLOT: begin
          i_r    <= start_nxt[IDX_W-1:0];
          end_r  <= end_nxt[IDX_W-1:0];
          wsum_r <= '0;
          msum_r <= '0;
          cnt_r  <= '0;
          acc_r  <= '0;
          st_r   <= ST_RD;
        end
        ST_RD: st_r <= ST_PP;
        ST_PP: begin
          m_r  <= (MASS_W+1)'(signed'(fm_rd_r)) + (MASS_W+1)'(signed'(sm_rd_r));
          st_r <= ST_WT;
        end
        ST_WT: begin
          w_r    <= w_round[63:31];
          neg_r  <= m_r[MASS_W];
          mag_r  <= m_r[MASS_W] ? (MASS_W+1)'(-m_r) : (MASS_W+1)'(m_r);
          wsum_r <= wsum_r + 37'(w_round[63:31]);
          msum_r <= msum_r + 46'(m_r);
          cnt_r  <= cnt_r + 1'b1;
          st_r   <= ST_ML;
        end
        ST_ML: st_r <= ST_MH;
        ST_MH: begin
          part_r <= mul_r[56:0];
          st_r   <= ST_MACC;
        end
        ST_MACC: begin
          acc_r <= neg_r ? acc_r - signed'(prod) : acc_r + signed'(prod);
          if (i_r == end_r) begin
            st_r <= ST_DIVS;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= ST_RD;
          end
        end
        ST_DIVS: begin
          mneg_r <= (wsum_r == '0) ? msum_r[45] : acc_r[DIV_NW-1];
          st_r   <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            if (found_r || sw_nxt > cutoff_r) tot_all_r <= tot_nxt;
            if (sw_nxt > cutoff_r) begin
              found_r  <= 1'b1;
              if (!found_r) lo_r <= k_r;
              hi_r     <= k_r;
              tot_hi_r <= tot_nxt;
            end
            if ((CNT_W+1)'(k_r) == last_k) begin
              st_r <= ST_FIN;
            end else begin
              k_r  <= k_r + 1'b1;
              st_r <= ST_SLOT;
            end
          end
        end
        ST_FIN: begin
          if (!found_r) begin
            spec_r      <= 1'b1;
            spec_stat_r <= STAT_PRUNED;
            st_r        <= ST_CHK;
          end else begin
            ek_r <= lo_r;
            st_r <= ST_ERD;
          end
        end
        ST_ERD: st_r <= ST_EDIV;
        ST_EDIV: st_r <= ST_EWT;
        ST_EWT: begin
          if (div_stat.done && !out_valid_r) begin
            out_r       <= '{out_mass: signed'(smass_rd_r), out_prob: div_quot[PROB_W-1:0],
                             out_last: (ek_r == hi_r), out_status: STAT_OK};
            out_valid_r <= 1'b1;
            if (ek_r == hi_r) begin
              st_r <= ST_IDLE;
            end else begin
              ek_r <= ek_r + 1'b1;
              st_r <= ST_ERD;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy) else $error("divider started while busy");

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.action && in_data.last_peak |=> !in_ready)
    else $error("run did not start on final item");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_status == STAT_OK |-> out_data.out_prob <= 32'h8000_0000)
    else $error("normalized probability above one");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_cnt_r <= CNT_W'(MAX_PEAKS) && second_cnt_r <= CNT_W'(MAX_PEAKS))
    else $error("peak count beyond store depth");

endmodule

// File: design/idc_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on idc_pkg for its widths and status struct.
module idc_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [idc_pkg::DIV_NW-1:0] num,
  input  logic [idc_pkg::DIV_DW-1:0] den,
  output logic [idc_pkg::DIV_NW-1:0] quot,
  output idc_pkg::div_stat_t         stat
);
  import idc_pkg::*;

  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;
  logic [DIV_DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[DIV_NW-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NW-2:0], fits};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quot      = num_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: sim/tb_isotope_distribution_convolution.sv
// Self-checking testbench for isotope_distribution_convolution: loads peak lists,
// predicts every convolution result and compares it on the result channel.
// Depends on idc_pkg and the RTL of the block.
module tb_isotope_distribution_convolution;
  timeunit 1ns;
  timeprecision 1ps;
  import idc_pkg::*;

  localparam longint MASS_TOP = (longint'(1) << 39) - 1;
  localparam longint MASS_BOT = -(longint'(1) << 39);
  localparam logic [31:0] PROB_ONE = 32'h8000_0000;
  localparam logic [2:0] ADDR_PRUNE_CUTOFF = 3'd0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  isotope_distribution_convolution dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_item_t pending_peaks[$];
  out_item_t expected_peaks[$];
  int send_idle = 32;
  int recv_idle = 69;
  int errors = 0;
  int cycles = 0;

  // Predictor state.
  longint first_m[MAX_PEAKS];
  logic [31:0] first_p[MAX_PEAKS];
  longint second_m[MAX_PEAKS];
  logic [31:0] second_p[MAX_PEAKS];
  int n_first = 0;
  int n_second = 0;
  bit overflowed = 1'b0;
  logic [31:0] cutoff = 32'd2147;

  function automatic void push_result(longint mass, logic [31:0] prob, logic last,
                                      status_t st);
    out_item_t r;
    r.out_mass = mass[39:0];
    r.out_prob = prob;
    r.out_last = last;
    r.out_status = st;
    expected_peaks = {expected_peaks, r};
  endfunction

  function automatic void convolve_lists();
    longint slot_m[SLOT_COUNT];
    logic [31:0] slot_w[SLOT_COUNT];
    int slots, lo, hi, first_i, last_i;
    longint unsigned w, wsum, total, q, p;
    longint m, msum;
    int cnt;
    logic signed [127:0] acc, mag;
    logic signed [127:0] mm, ww;
    slots = n_first + n_second - 1;
    for (int k = 0; k < slots; k++) begin
      first_i = (k < n_second - 1) ? 0 : k - n_second + 1;
      last_i = (k < n_first - 1) ? k : n_first - 1;
      wsum = 0;
      msum = 0;
      cnt = 0;
      acc = '0;
      for (int i = first_i; i <= last_i; i++) begin
        w = (longint'(first_p[i]) * longint'(second_p[k - i]) + (64'd1 << 30)) >> 31;
        m = first_m[i] + second_m[k - i];
        mm = m;
        ww = w;
        acc = acc + mm * ww;
        wsum += w;
        msum += m;
        cnt++;
      end
      if (wsum == 0) begin
        q = ((msum < 0 ? -msum : msum) + cnt / 2) / cnt;
        m = (msum < 0) ? -longint'(q) : longint'(q);
      end else begin
        mag = acc < 0 ? -acc : acc;
        mag = (mag + wsum / 2) / wsum;
        if (mag > (128'sd1 <<< 40)) mag = 128'sd1 <<< 40;
        m = (acc < 0) ? -longint'(mag) : longint'(mag);
      end
      slot_m[k] = (m > MASS_TOP) ? MASS_TOP : (m < MASS_BOT) ? MASS_BOT : m;
      slot_w[k] = (wsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wsum[31:0];
    end
    lo = 0;
    while (lo < slots && slot_w[lo] <= cutoff) lo++;
    if (lo == slots) begin
      push_result(0, 0, 1'b1, STAT_PRUNED);
      return;
    end
    hi = slots - 1;
    while (hi > lo && slot_w[hi] <= cutoff) hi--;
    total = 0;
    for (int k = lo; k <= hi; k++) total += slot_w[k];
    for (int k = lo; k <= hi; k++) begin
      p = ((longint'(slot_w[k]) << 31) + total / 2) / total;
      push_result(slot_m[k], p[31:0], k == hi, STAT_OK);
    end
  endfunction

  function automatic void predict_peak(in_item_t it);
    longint mass;
    mass = longint'(it.peak_mass);
    if (!it.action) begin
      if (n_first < MAX_PEAKS) begin
        first_m[n_first] = mass;
        first_p[n_first] = it.peak_prob;
        n_first++;
      end else begin
        overflowed = 1'b1;
      end
      return;
    end
    if (n_second < MAX_PEAKS) begin
      second_m[n_second] = mass;
      second_p[n_second] = it.peak_prob;
      n_second++;
    end else begin
      overflowed = 1'b1;
    end
    if (!it.last_peak) return;
    if (overflowed) push_result(0, 0, 1'b1, STAT_OVERFLOW);
    else if (n_first == 0 || n_second == 0) push_result(0, 0, 1'b1, STAT_PRUNED);
    else convolve_lists();
    n_first = 0;
    n_second = 0;
    overflowed = 1'b0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Driver and predictor hook on the input channel.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_peak(in_data);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_peaks.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= pending_peaks.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor on the result channel.
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_peaks.size() == 0) begin
        report_mismatch("unexpected item", longint'(out_data.out_mass), 0);
      end else begin
        want = expected_peaks.pop_front();
        if (out_data.out_mass !== want.out_mass)
          report_mismatch("out_mass", longint'(out_data.out_mass), longint'(want.out_mass));
        if (out_data.out_prob !== want.out_prob)
          report_mismatch("out_prob", longint'(out_data.out_prob), longint'(want.out_prob));
        if (out_data.out_last !== want.out_last)
          report_mismatch("out_last", longint'(out_data.out_last), longint'(want.out_last));
        if (out_data.out_status !== want.out_status)
          report_mismatch("out_status", longint'(out_data.out_status),
                          longint'(want.out_status));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (cycles > 10000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [39:0] rand_mass();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) == 0) return r[39:0];
    return (40'($urandom_range(2000)) << 24) + 40'($urandom_range(24'hFF_FFFF));
  endfunction

  function automatic logic [31:0] rand_prob();
    unique case ($urandom_range(4))
      0: return 32'd0;
      1: return PROB_ONE;
      2: return $urandom_range(5000);
      default: return $urandom_range(PROB_ONE);
    endcase
  endfunction

  task automatic add_peak(logic act, logic signed [39:0] mass, logic [31:0] prob,
                          logic last);
    in_item_t it;
    it.action = act;
    it.peak_mass = mass;
    it.peak_prob = prob;
    it.last_peak = last;
    pending_peaks = {pending_peaks, it};
  endtask

  // One run: n0 first peaks and n1 second peaks, optionally interleaved.
  task automatic queue_run(int n0, int n1, bit mix);
    int a, b;
    a = 0;
    b = 0;
    while (a < n0 || b < n1 - 1) begin
      if (a < n0 && (!mix || b >= n1 - 1 || $urandom_range(1))) begin
        add_peak(1'b0, rand_mass(), rand_prob(), a == n0 - 1);
        a++;
      end else begin
        add_peak(1'b1, rand_mass(), rand_prob(), 1'b0);
        b++;
      end
    end
    add_peak(1'b1, rand_mass(), rand_prob(), 1'b1);
  endtask

  task automatic drain_and_write(logic [31:0] value);
    while (pending_peaks.size() > 0 || in_valid || expected_peaks.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_PRUNE_CUTOFF;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cutoff = value;
  endtask

  task automatic random_phase(int items);
    int r, n0, n1;
    int start;
    start = pending_peaks.size();
    while (pending_peaks.size() - start < items) begin
      r = $urandom_range(99);
      if (r < 3) begin
        n0 = MAX_PEAKS;
        n1 = MAX_PEAKS;
      end else if (r < 6) begin
        n0 = $urandom_range(1) ? MAX_PEAKS + 1 : 2;
        n1 = (n0 == 2) ? MAX_PEAKS + 1 : 2;
      end else begin
        n0 = $urandom_range(5);
        n1 = $urandom_range(1, 5);
      end
      queue_run(n0, n1, $urandom_range(1));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset cutoff.
    add_peak(1'b1, rand_mass(), PROB_ONE, 1'b1);
    add_peak(1'b0, 40'sh7F_FFFF_FFFF, PROB_ONE, 1'b0);
    add_peak(1'b0, 40'sh80_0000_0000, 32'd0, 1'b1);
    add_peak(1'b1, 40'sh7F_FFFF_FFFF, PROB_ONE, 1'b0);
    add_peak(1'b1, 40'sh80_0000_0000, 32'hFFFF_FFFF, 1'b1);
    add_peak(1'b0, rand_mass(), 32'd0, 1'b1);
    add_peak(1'b1, rand_mass(), 32'd2147, 1'b1);
    for (int i = 0; i <= MAX_PEAKS; i++)
      add_peak(1'b0, rand_mass(), rand_prob(), i == MAX_PEAKS);
    add_peak(1'b1, rand_mass(), rand_prob(), 1'b1);
    random_phase(40);

    drain_and_write(32'd0);
    random_phase(140);

    drain_and_write(PROB_ONE);
    send_idle = 69;
    recv_idle = 32;
    random_phase(60);

    drain_and_write($urandom_range(PROB_ONE));
    random_phase(70);

    drain_and_write(32'd2147);
    send_idle = 0;
    recv_idle = 0;
    random_phase(140);

    while (pending_peaks.size() > 0 || in_valid || expected_peaks.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
